// File: rtl/fjd_pkg.sv
// ============================================================================
// fjd_pkg
// Shared types and constants for the multi-server FIFO job dispatcher.
// ============================================================================
package fjd_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 64;
    localparam int unsigned DEF_MAX_SERVERS = 8;

    localparam int unsigned ID_W       = 16;
    localparam int unsigned PAGES_W    = 16;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned SRV_OUT_W  = 3;
    localparam int unsigned ACTIVE_W   = 4;
    localparam int unsigned ENTRY_W    = ID_W + PAGES_W;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(1);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM    = 2'd2;

    // input actions
    localparam logic ACT_ENQ  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;     // capture accepted item, restart server walk
        logic enq;          // do enqueue, load reply
        logic next_srv;     // skip current server
        logic assign_job;   // hand queue head to current server, load result
        logic countdown;    // decrement all busy servers, evaluate work left
        logic summary;      // load tick summary
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_action;    // action bit of the item on the input port
        logic walk_done;    // all active servers visited
        logic can_assign;   // current server idle and queue not empty
        logic out_free;     // output register can take a result this cycle
    } t_status;

endpackage

// File: rtl/fjd_ctrl.sv
// ============================================================================
// fjd_ctrl
// Sequencer: accepts one item at a time and steps the datapath through the
// enqueue or the tick walk, countdown and summary.
// ============================================================================
module fjd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fjd_pkg::t_status i_status,
    output fjd_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ENQ    = 3'd1;
    localparam logic [2:0] S_VISIT  = 3'd2;
    localparam logic [2:0] S_ASSIGN = 3'd3;
    localparam logic [2:0] S_COUNT  = 3'd4;
    localparam logic [2:0] S_SUM    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = (i_status.in_action == fjd_pkg::ACT_TICK) ? S_VISIT : S_ENQ;
                end
            end
            S_ENQ: begin
                if (i_status.out_free) begin
                    o_cmd.enq = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_VISIT: begin
                if (i_status.walk_done) begin
                    n_state = S_COUNT;
                end else if (i_status.can_assign) begin
                    n_state = S_ASSIGN;
                end else begin
                    o_cmd.next_srv = 1'b1;
                end
            end
            S_ASSIGN: begin
                if (i_status.out_free) begin
                    o_cmd.assign_job = 1'b1;
                    n_state          = S_VISIT;
                end
            end
            S_COUNT: begin
                o_cmd.countdown = 1'b1;
                n_state         = S_SUM;
            end
            S_SUM: begin
                if (i_status.out_free) begin
                    o_cmd.summary = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/fjd_datapath.sv
// ============================================================================
// fjd_datapath
// Job queue memory, server timers, page total, configuration register and
// the output result register.
// ============================================================================
module fjd_datapath #(
    parameter int unsigned QUEUE_DEPTH = fjd_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned MAX_SERVERS = fjd_pkg::DEF_MAX_SERVERS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fjd_pkg::ACTIVE_W-1:0]      i_cfg_data,
    input  logic                              i_action,
    input  logic [fjd_pkg::ID_W-1:0]          i_job_id,
    input  logic [fjd_pkg::PAGES_W-1:0]       i_job_pages,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [fjd_pkg::KIND_W-1:0]        o_kind,
    output logic                              o_refused,
    output logic [fjd_pkg::SRV_OUT_W-1:0]     o_server_index,
    output logic [fjd_pkg::ID_W-1:0]          o_assigned_id,
    output logic [fjd_pkg::PAGES_W-1:0]       o_assigned_pages,
    output logic [fjd_pkg::TOTAL_W-1:0]       o_total_pages,
    output logic                              o_work_left,
    output logic                              o_last,
    input  fjd_pkg::t_cmd                     i_cmd,
    output fjd_pkg::t_status                  o_status
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int unsigned WALK_W = $clog2(MAX_SERVERS + 1);
    localparam int unsigned CMP_W = (WALK_W > fjd_pkg::ACTIVE_W) ? WALK_W : fjd_pkg::ACTIVE_W;

    // job queue storage, entry = {id, pages}
    logic [fjd_pkg::ENTRY_W-1:0] r_mem [QUEUE_DEPTH];
    logic [fjd_pkg::ENTRY_W-1:0] r_head_data;

    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [fjd_pkg::PAGES_W-1:0] r_rem [MAX_SERVERS];
    logic [fjd_pkg::TOTAL_W-1:0] r_total;
    logic [fjd_pkg::ACTIVE_W-1:0] r_active;
    logic [WALK_W-1:0] r_srv;
    logic              r_left;

    logic [fjd_pkg::ID_W-1:0]    r_id;
    logic [fjd_pkg::PAGES_W-1:0] r_pages;

    logic                         full;
    logic [CMP_W-1:0]             n_walk;
    logic [CMP_W-1:0]             active_ext;
    logic [SRV_W-1:0]             srv_idx;
    logic [fjd_pkg::PAGES_W-1:0]  head_pages;
    logic [fjd_pkg::ID_W-1:0]     head_id;
    logic [fjd_pkg::TOTAL_W-1:0]  total_next;
    logic [SRV_W+fjd_pkg::SRV_OUT_W-1:0] srv_ext;
    logic                         any_busy_after;
    logic                         out_free;
    logic                         out_load;

    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign active_ext = CMP_W'(r_active);
    // active count saturates at the number of servers built
    assign n_walk     = (active_ext > CMP_W'(MAX_SERVERS)) ? CMP_W'(MAX_SERVERS) : active_ext;
    assign srv_idx    = r_srv[SRV_W-1:0];
    assign head_pages = r_head_data[fjd_pkg::PAGES_W-1:0];
    assign head_id    = r_head_data[fjd_pkg::ENTRY_W-1:fjd_pkg::PAGES_W];
    assign total_next = r_total + fjd_pkg::TOTAL_W'(head_pages);
    assign srv_ext    = {{fjd_pkg::SRV_OUT_W{1'b0}}, srv_idx};

    // a server is still busy after the countdown if it holds more than one tick
    always_comb begin
        any_busy_after = 1'b0;
        for (int j = 0; j < MAX_SERVERS; j++) begin
            if (r_rem[j] > fjd_pkg::PAGES_W'(1)) begin
                any_busy_after = 1'b1;
            end
        end
    end

    assign out_free = !o_out_valid || !i_out_stall;
    assign out_load = i_cmd.enq || i_cmd.assign_job || i_cmd.summary;

    assign o_status.in_action  = i_action;
    assign o_status.walk_done  = (CMP_W'(r_srv) >= n_walk);
    assign o_status.can_assign = (r_rem[srv_idx] == '0) && (r_count != '0);
    assign o_status.out_free   = out_free;

    // queue memory: one write port, registered read of the head entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq && !full) begin
            r_mem[r_tail] <= {r_id, r_pages};
        end
        r_head_data <= r_mem[r_head];
    end

    // item capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_id    <= i_job_id;
            r_pages <= i_job_pages;
        end
    end

    // queue pointers, total, config, walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_active <= fjd_pkg::ACTIVE_RESET;
            r_srv    <= '0;
            r_left   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (i_cmd.latch_in) begin
                r_srv <= '0;
            end else if (i_cmd.next_srv || i_cmd.assign_job) begin
                r_srv <= r_srv + WALK_W'(1);
            end
            if (i_cmd.enq && !full) begin
                r_tail  <= (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.assign_job) begin
                r_head  <= (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
                r_count <= r_count - CNT_W'(1);
                r_total <= total_next;
            end
            if (i_cmd.countdown) begin
                r_left <= (r_count != '0) || any_busy_after;
            end
        end
    end

    // server timers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_SERVERS; j++) begin
                r_rem[j] <= '0;
            end
        end else if (i_cmd.assign_job) begin
            r_rem[srv_idx] <= head_pages;
        end else if (i_cmd.countdown) begin
            for (int j = 0; j < MAX_SERVERS; j++) begin
                if (r_rem[j] != '0) begin
                    r_rem[j] <= r_rem[j] - fjd_pkg::PAGES_W'(1);
                end
            end
        end
    end

    // output result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_refused        <= 1'b0;
            o_server_index   <= '0;
            o_assigned_id    <= '0;
            o_assigned_pages <= '0;
            o_total_pages    <= '0;
            o_work_left      <= 1'b0;
            o_last           <= 1'b1;
            if (i_cmd.enq) begin
                o_kind    <= fjd_pkg::KIND_ENQ;
                o_refused <= full;
            end else if (i_cmd.assign_job) begin
                o_kind           <= fjd_pkg::KIND_ASSIGN;
                o_server_index   <= srv_ext[fjd_pkg::SRV_OUT_W-1:0];
                o_assigned_id    <= head_id;
                o_assigned_pages <= head_pages;
                o_total_pages    <= total_next;
                o_last           <= 1'b0;
            end else begin
                o_kind        <= fjd_pkg::KIND_SUM;
                o_total_pages <= r_total;
                o_work_left   <= r_left;
            end
        end
    end

endmodule

// File: rtl/fifo_job_dispatcher_multi_server_unit.sv
// ============================================================================
// fifo_job_dispatcher_multi_server_unit
// Multi-server FIFO job dispatcher: queued jobs are handed to idle servers on
// each tick, with a per-tick summary of the running page total.
// ============================================================================
//
// One item is taken at a time; in_stall stays high until its last result has
// been loaded into the output register. An enqueue gives one reply (refused
// set when the queue is full). A tick first takes the item, then the
// sequencer visits the n = min(active_servers, MAX_SERVERS) servers, one
// server per cycle while no assignment holds it, and makes one more visit to
// see that the walk is done; each assignment adds a step of its own (the
// queue head comes out of a registered memory read); then all servers count
// down and the summary is loaded. Every result waits in a single output
// register, so output stall holds the sequencer in the step that loads it.
// Results of a tick: one assignment per server that took a job, in server
// order, then the summary flagged last. The queue lives in a QUEUE_DEPTH-entry
// memory with no reset; pointers and count clear at reset, and only entries
// written by an enqueue are ever read. active_servers resets to 1 and is
// written through i_cfg_we / i_cfg_data; the user must write it only while
// the block is idle, and the block itself does not enforce this.
//
module fifo_job_dispatcher_multi_server_unit #(
    parameter int unsigned QUEUE_DEPTH = fjd_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned MAX_SERVERS = fjd_pkg::DEF_MAX_SERVERS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: active_servers
    input  logic                              i_cfg_we,
    input  logic [fjd_pkg::ACTIVE_W-1:0]      i_cfg_data,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [fjd_pkg::ID_W-1:0]          i_job_id,
    input  logic [fjd_pkg::PAGES_W-1:0]       i_job_pages,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [fjd_pkg::KIND_W-1:0]        o_kind,
    output logic                              o_refused,
    output logic [fjd_pkg::SRV_OUT_W-1:0]     o_server_index,
    output logic [fjd_pkg::ID_W-1:0]          o_assigned_id,
    output logic [fjd_pkg::PAGES_W-1:0]       o_assigned_pages,
    output logic [fjd_pkg::TOTAL_W-1:0]       o_total_pages,
    output logic                              o_work_left,
    output logic                              o_last
);

    fjd_pkg::t_cmd    cmd;
    fjd_pkg::t_status status;

    // sequencer: owns the input handshake
    fjd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // queue, server timers, total and output register
    fjd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_SERVERS (MAX_SERVERS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_job_id         (i_job_id),
        .i_job_pages      (i_job_pages),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_refused        (o_refused),
        .o_server_index   (o_server_index),
        .o_assigned_id    (o_assigned_id),
        .o_assigned_pages (o_assigned_pages),
        .o_total_pages    (o_total_pages),
        .o_work_left      (o_work_left),
        .o_last           (o_last),
        .i_cmd            (cmd),
        .o_status         (status)
    );

endmodule
